### design/imad_pkg.sv
// Package for the IMA ADPCM decoder: opcodes, limits, step and index tables,
// and the structs passed between the top level and the nibble step unit.
// No dependencies.
package imad_pkg;

    localparam logic [1:0] OP_HEADER  = 2'd0;
    localparam logic [1:0] OP_DECODE  = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    localparam logic [6:0]         IDX_MAX  = 7'd88;
    localparam logic signed [16:0] PRED_MAX = 17'sd32767;
    localparam logic signed [16:0] PRED_MIN = -17'sd32767;

    localparam int NIBBLES = 8;

    typedef struct packed {
        logic signed [15:0] predictor;
        logic [6:0]         step_index;
        logic [3:0]         code;
    } step_in_t;

    typedef struct packed {
        logic signed [15:0] predictor;
        logic [6:0]         step_index;
    } step_out_t;

    function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
        logic signed [7:0] adj;
        case (mag)
            3'd4:    adj = 8'sd2;
            3'd5:    adj = 8'sd4;
            3'd6:    adj = 8'sd6;
            3'd7:    adj = 8'sd8;
            default: adj = -8'sd1;
        endcase
        return adj;
    endfunction

    function automatic logic [14:0] step_table(input logic [6:0] idx);
        logic [15:0] s;
        case (idx)
            7'd0:  s = 16'h0007; 7'd1:  s = 16'h0008; 7'd2:  s = 16'h0009; 7'd3:  s = 16'h000A;
            7'd4:  s = 16'h000B; 7'd5:  s = 16'h000C; 7'd6:  s = 16'h000D; 7'd7:  s = 16'h000E;
            7'd8:  s = 16'h0010; 7'd9:  s = 16'h0011; 7'd10: s = 16'h0013; 7'd11: s = 16'h0015;
            7'd12: s = 16'h0017; 7'd13: s = 16'h0019; 7'd14: s = 16'h001C; 7'd15: s = 16'h001F;
            7'd16: s = 16'h0022; 7'd17: s = 16'h0025; 7'd18: s = 16'h0029; 7'd19: s = 16'h002D;
            7'd20: s = 16'h0032; 7'd21: s = 16'h0037; 7'd22: s = 16'h003C; 7'd23: s = 16'h0042;
            7'd24: s = 16'h0049; 7'd25: s = 16'h0050; 7'd26: s = 16'h0058; 7'd27: s = 16'h0061;
            7'd28: s = 16'h006B; 7'd29: s = 16'h0076; 7'd30: s = 16'h0082; 7'd31: s = 16'h008F;
            7'd32: s = 16'h009D; 7'd33: s = 16'h00AD; 7'd34: s = 16'h00BE; 7'd35: s = 16'h00D1;
            7'd36: s = 16'h00E6; 7'd37: s = 16'h00FD; 7'd38: s = 16'h0117; 7'd39: s = 16'h0133;
            7'd40: s = 16'h0151; 7'd41: s = 16'h0173; 7'd42: s = 16'h0198; 7'd43: s = 16'h01C1;
            7'd44: s = 16'h01EE; 7'd45: s = 16'h0220; 7'd46: s = 16'h0256; 7'd47: s = 16'h0292;
            7'd48: s = 16'h02D4; 7'd49: s = 16'h031C; 7'd50: s = 16'h036C; 7'd51: s = 16'h03C3;
            7'd52: s = 16'h0424; 7'd53: s = 16'h048E; 7'd54: s = 16'h0502; 7'd55: s = 16'h0583;
            7'd56: s = 16'h0610; 7'd57: s = 16'h06AB; 7'd58: s = 16'h0756; 7'd59: s = 16'h0812;
            7'd60: s = 16'h08E0; 7'd61: s = 16'h09C3; 7'd62: s = 16'h0ABD; 7'd63: s = 16'h0BD0;
            7'd64: s = 16'h0CFF; 7'd65: s = 16'h0E4C; 7'd66: s = 16'h0FBA; 7'd67: s = 16'h114C;
            7'd68: s = 16'h1307; 7'd69: s = 16'h14EE; 7'd70: s = 16'h1706; 7'd71: s = 16'h1954;
            7'd72: s = 16'h1BDC; 7'd73: s = 16'h1EA5; 7'd74: s = 16'h21B6; 7'd75: s = 16'h2515;
            7'd76: s = 16'h28CA; 7'd77: s = 16'h2CDF; 7'd78: s = 16'h315B; 7'd79: s = 16'h364B;
            7'd80: s = 16'h3BB9; 7'd81: s = 16'h41B2; 7'd82: s = 16'h4844; 7'd83: s = 16'h4F7E;
            7'd84: s = 16'h5771; 7'd85: s = 16'h602F; 7'd86: s = 16'h69CE; 7'd87: s = 16'h7462;
            default: s = 16'h7FFF;
        endcase
        return s[14:0];
    endfunction

endpackage

### design/imad_nibble_step.sv
// One ADPCM nibble step: step lookup, difference, saturating predictor update
// and step index update. Combinational. Depends on imad_pkg.
module imad_nibble_step
    import imad_pkg::*;
(
    input  step_in_t  step_i,
    output step_out_t step_o
);

    logic [14:0]        step;
    logic [2:0]         mag;
    logic [18:0]        prod;
    logic signed [17:0] diff_ext;
    logic signed [17:0] pred_ext;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_sum;

    assign mag      = step_i.code[2:0];
    assign step     = step_table(step_i.step_index);
    assign prod     = 19'(step) * 19'({mag, 1'b1});
    assign diff_ext = $signed({2'b00, prod[18:3]});
    assign pred_ext = 18'(step_i.predictor);
    assign idx_sum  = $signed({1'b0, step_i.step_index}) + idx_adjust(mag);

    always_comb begin
        if (step_i.code[3]) begin
            sum = pred_ext - diff_ext;
            if (sum < PRED_MIN) begin
                sum = 18'(PRED_MIN);
            end
        end else begin
            sum = pred_ext + diff_ext;
            if (sum > PRED_MAX) begin
                sum = 18'(PRED_MAX);
            end
        end
        step_o.predictor = sum[15:0];

        if (idx_sum < 8'sd0) begin
            step_o.step_index = 7'd0;
        end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
            step_o.step_index = IDX_MAX;
        end else begin
            step_o.step_index = idx_sum[6:0];
        end
    end

endmodule

### design/ima_adpcm_decoder_unit.sv
// Top level of the IMA ADPCM decoder: input word register, nibble sequencer,
// decoder state and output register. Depends on imad_pkg and imad_nibble_step.
//
// A header item (tuser 0) loads predictor and step index and saves them as the
// loop state; a restore item (tuser 2) reloads the loop state; both produce no
// output. A data item (tuser 1) produces eight samples, low nibble first, one
// per cycle while the output is not stalled, through a single nibble step unit
// whose result feeds the next nibble; the eighth carries tlast. A new item is
// taken in the cycle the eighth sample is registered, so data words follow one
// another with no gap. The output register decouples downstream stalls, which
// pause the sequence. Item code 3 is accepted and ignored.
module ima_adpcm_decoder_unit
    import imad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] word
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
    output logic        m_axis_tlast
);

    logic               busy_reg;
    logic [2:0]         nib_cnt_reg;
    logic [31:0]        word_reg;
    logic signed [15:0] predictor_reg;
    logic [6:0]         step_index_reg;
    logic signed [15:0] loop_predictor_reg;
    logic [6:0]         loop_step_index_reg;
    logic               out_valid_reg;
    logic [15:0]        out_sample_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               advance;
    logic               last_nib;
    logic               accept;
    logic [6:0]         hdr_idx;
    step_in_t           step_in;
    step_out_t          step_out;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = busy_reg && out_free;
    assign last_nib      = (nib_cnt_reg == 3'(NIBBLES - 1));
    assign s_axis_tready = !busy_reg || (out_free && last_nib);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hdr_idx       = (s_axis_tdata[22:16] > IDX_MAX) ? IDX_MAX : s_axis_tdata[22:16];

    assign step_in.predictor  = predictor_reg;
    assign step_in.step_index = step_index_reg;
    assign step_in.code       = word_reg[{nib_cnt_reg, 2'b00} +: 4];

    imad_nibble_step u_step (
        .step_i (step_in),
        .step_o (step_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg            <= 1'b0;
            nib_cnt_reg         <= 3'd0;
            predictor_reg       <= 16'sd0;
            step_index_reg      <= 7'd0;
            loop_predictor_reg  <= 16'sd0;
            loop_step_index_reg <= 7'd0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= advance;
            end
            if (advance) begin
                predictor_reg  <= step_out.predictor;
                step_index_reg <= step_out.step_index;
                nib_cnt_reg    <= nib_cnt_reg + 3'd1;
                if (last_nib) begin
                    busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                case (s_axis_tuser)
                    OP_HEADER: begin
                        predictor_reg       <= s_axis_tdata[15:0];
                        step_index_reg      <= hdr_idx;
                        loop_predictor_reg  <= s_axis_tdata[15:0];
                        loop_step_index_reg <= hdr_idx;
                    end
                    OP_RESTORE: begin
                        predictor_reg  <= loop_predictor_reg;
                        step_index_reg <= loop_step_index_reg;
                    end
                    OP_DECODE: begin
                        busy_reg    <= 1'b1;
                        nib_cnt_reg <= 3'd0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_axis_tuser == OP_DECODE) begin
            word_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_sample_reg <= step_out.predictor;
            out_last_reg   <= last_nib;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_last_reg;

    a_decode_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == OP_DECODE) |=> (busy_reg && nib_cnt_reg == 3'd0))
        else $error("decode item did not start the nibble sequence");

    a_ready_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tready && busy_reg) |-> (last_nib && out_free))
        else $error("input taken while a data word is still in progress");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_index_reg <= IDX_MAX) && (loop_step_index_reg <= IDX_MAX))
        else $error("step index out of range");

    a_last_ends_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_nib && !accept) |=> !busy_reg)
        else $error("sequencer kept running past the eighth nibble");

endmodule

### tb/adpcm_sample_checker.sv
// Checker for the IMA ADPCM decoder: watches both stream channels, predicts
// the samples of each accepted item and compares them in order.
// Depends on imad_pkg.
module adpcm_sample_checker
    import imad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] word
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } pcm_result_t;

    // step sizes, index 0 first; read as STEP_SIZES[(88 - idx)*16 +: 16]
    localparam logic [89*16-1:0] STEP_SIZES = {
        16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
        16'h0010, 16'h0011, 16'h0013, 16'h0015, 16'h0017, 16'h0019, 16'h001C, 16'h001F,
        16'h0022, 16'h0025, 16'h0029, 16'h002D, 16'h0032, 16'h0037, 16'h003C, 16'h0042,
        16'h0049, 16'h0050, 16'h0058, 16'h0061, 16'h006B, 16'h0076, 16'h0082, 16'h008F,
        16'h009D, 16'h00AD, 16'h00BE, 16'h00D1, 16'h00E6, 16'h00FD, 16'h0117, 16'h0133,
        16'h0151, 16'h0173, 16'h0198, 16'h01C1, 16'h01EE, 16'h0220, 16'h0256, 16'h0292,
        16'h02D4, 16'h031C, 16'h036C, 16'h03C3, 16'h0424, 16'h048E, 16'h0502, 16'h0583,
        16'h0610, 16'h06AB, 16'h0756, 16'h0812, 16'h08E0, 16'h09C3, 16'h0ABD, 16'h0BD0,
        16'h0CFF, 16'h0E4C, 16'h0FBA, 16'h114C, 16'h1307, 16'h14EE, 16'h1706, 16'h1954,
        16'h1BDC, 16'h1EA5, 16'h21B6, 16'h2515, 16'h28CA, 16'h2CDF, 16'h315B, 16'h364B,
        16'h3BB9, 16'h41B2, 16'h4844, 16'h4F7E, 16'h5771, 16'h602F, 16'h69CE, 16'h7462,
        16'h7FFF
    };

    pcm_result_t        expected_pcm[$];
    pcm_result_t        want;
    logic signed [15:0] cur_pred;
    logic signed [15:0] saved_pred;
    logic [6:0]         cur_index;
    logic [6:0]         saved_index;
    int                 fail_count;

    function automatic logic [6:0] limit_index(input int v);
        if (v < 0)
            return 7'd0;
        if (v > int'(IDX_MAX))
            return IDX_MAX;
        return v[6:0];
    endfunction

    task automatic decode_word(input logic [31:0] w);
        logic [3:0] code;
        logic [2:0] mag;
        int         step;
        int         diff;
        int         acc;
        int         adj;
        for (int k = 0; k < NIBBLES; k++) begin
            code = w[4*k +: 4];
            mag  = code[2:0];
            step = int'(STEP_SIZES[(88 - int'(cur_index))*16 +: 16]);
            diff = (step * (2 * int'(mag) + 1)) >>> 3;
            acc  = int'(cur_pred);
            if (code[3]) begin
                acc = acc - diff;
                if (acc < int'(PRED_MIN))
                    acc = int'(PRED_MIN);
            end else begin
                acc = acc + diff;
                if (acc > int'(PRED_MAX))
                    acc = int'(PRED_MAX);
            end
            adj = mag[2] ? 2 * (int'(mag[1:0]) + 1) : -1;
            cur_index = limit_index(int'(cur_index) + adj);
            cur_pred  = acc[15:0];
            expected_pcm.push_back('{sample: acc[15:0], last: (k == NIBBLES - 1)});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_pred    = '0;
            cur_index   = '0;
            saved_pred  = '0;
            saved_index = '0;
            fail_count  = 0;
            expected_pcm.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pcm.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected sample %0d last %0d",
                                 $signed(m_axis_tdata), m_axis_tlast);
                end else begin
                    want = expected_pcm.pop_front();
                    if (want.sample !== m_axis_tdata || want.last !== m_axis_tlast) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("sample mismatch: expected %0d last %0d, got %0d last %0d",
                                     $signed(want.sample), want.last,
                                     $signed(m_axis_tdata), m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_HEADER: begin
                        cur_pred    = s_axis_tdata[15:0];
                        cur_index   = limit_index(int'(s_axis_tdata[22:16]));
                        saved_pred  = cur_pred;
                        saved_index = cur_index;
                    end
                    OP_DECODE: begin
                        decode_word(s_axis_tdata);
                    end
                    OP_RESTORE: begin
                        cur_pred  = saved_pred;
                        cur_index = saved_index;
                    end
                    default: ;
                endcase
            end
        end
        mismatches <= fail_count;
        pending    <= expected_pcm.size();
    end

endmodule

### tb/tb.sv
// Top of the IMA ADPCM decoder testbench: clock, reset, item stimulus with
// random gaps and stalls, and the verdict. Depends on imad_pkg,
// ima_adpcm_decoder_unit and adpcm_sample_checker.
module tb
    import imad_pkg::*;
;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET = 360;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] word
    logic [1:0]  s_axis_tuser;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] pcm_sample
    logic        m_axis_tlast;

    int          mismatches;
    int          pending;
    int          cycle_count;
    int          item_count;
    int          words_in_run;
    int          out_stall;
    logic        no_idle;
    logic [31:0] rand_word;
    logic [1:0]  rand_op;

    ima_adpcm_decoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    adpcm_sample_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] op, input logic [31:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        @(negedge aclk);
        if (op != OP_UNUSED)
            item_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
        @(negedge aclk);
    endtask

    // result side: a random stall, possibly none, before each sample
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            out_stall = no_idle ? 0 : $urandom_range(0, 6);
            if (out_stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (out_stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_HEADER;
        no_idle       = 1'b0;
        item_count    = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        send_item(OP_DECODE,  32'h0000_0000);
        send_item(OP_HEADER,  32'h0000_8000);   // -32768, smallest step
        send_item(OP_DECODE,  32'h0000_0000);
        send_item(OP_HEADER,  32'h0058_8000);
        send_item(OP_DECODE,  32'h8888_8888);
        send_item(OP_HEADER,  32'h0058_7FFF);
        send_item(OP_DECODE,  32'h7777_7777);
        send_item(OP_HEADER,  32'h007F_0000);   // index above range
        send_item(OP_DECODE,  32'hFFFF_FFFF);
        send_item(OP_RESTORE, 32'h0000_0000);
        send_item(OP_DECODE,  32'h0F0F_0F0F);
        send_item(OP_UNUSED,  32'hFFFF_FFFF);
        send_item(OP_DECODE,  32'h1234_5678);
        send_item(OP_HEADER,  32'hFF80_1234);
        send_item(OP_DECODE,  32'hFEDC_BA98);
        send_item(OP_RESTORE, 32'hFFFF_FFFF);
        send_item(OP_DECODE,  32'h7654_3210);
        send_item(OP_HEADER,  32'h0059_C000);
        send_item(OP_DECODE,  32'hA5A5_A5A5);
        send_item(OP_DECODE,  32'h7777_7777);
        send_item(OP_DECODE,  32'h0000_0000);
        wait_drained();

        // random part: mostly header, data words, optional restore and replay
        while (item_count < ITEM_TARGET) begin
            no_idle = (item_count >= 150 && item_count < 200);
            if ($urandom_range(0, 29) == 0)
                wait_drained();
            if ($urandom_range(0, 99) < 85) begin
                rand_word = $urandom;
                if ($urandom_range(0, 9) < 7)
                    rand_word[22:16] = 7'($urandom_range(0, 88));
                send_item(OP_HEADER, rand_word);
                words_in_run = $urandom_range(1, 6);
                repeat (words_in_run) send_item(OP_DECODE, $urandom);
                if ($urandom_range(0, 1) == 1) begin
                    send_item(OP_RESTORE, $urandom);
                    words_in_run = $urandom_range(1, 3);
                    repeat (words_in_run) send_item(OP_DECODE, $urandom);
                end
            end else begin
                rand_op = 2'($urandom_range(0, 3));
                send_item(rand_op, $urandom);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
